>>> rtl/fgno_pkg.sv
`timescale 1ns / 1ps
// shared types and constants of the film grain overlay
// no dependencies
package fgno_pkg;

   typedef struct packed {
      logic [15:0] pixel_x;
      logic [15:0] pixel_y;
      logic [15:0] red_in;
      logic [15:0] green_in;
      logic [15:0] blue_in;
   } fgno_req_type;

   typedef struct packed {
      logic [15:0] red_out;
      logic [15:0] green_out;
      logic [15:0] blue_out;
   } fgno_rsp_type;

   // lattice step and hash seed of one noise field
   typedef struct packed {
      logic [16:0] step;
      logic [31:0] seed;
   } fgno_field_type;

   typedef enum logic [1:0] {
      CSR_SEED = 2'd0,
      CSR_STEP = 2'd1,
      CSR_GAIN = 2'd2
   } fgno_csr_type;

   localparam logic [31:0] MIX_M1     = 32'h7feb352d;
   localparam logic [31:0] MIX_M2     = 32'h846ca68b;
   localparam logic [31:0] HASH_X     = 32'h1f123bb5;
   localparam logic [31:0] HASH_Y     = 32'h5f356495;
   localparam logic [31:0] SEED_CLUMP = 32'h9e3779b9;
   localparam logic [31:0] SEED_COLOR = 32'ha511e9b3;

   localparam logic [16:0] STEP_MAX   = 17'd65536;
   localparam logic [31:0] CLUMP_K    = 32'd24273;
   localparam logic [31:0] COLOR_K    = 32'd48545;
   localparam logic [31:0] ROUND_HALF = 32'd32768;

   localparam logic [16:0] CLUMP_STEP_RST =
      17'((64'd65536 * 64'd24273 + 64'd32768) >> 16);
   localparam logic [16:0] COLOR_STEP_RST =
      17'((64'd65536 * 64'd48545 + 64'd32768) >> 16);
   localparam logic [16:0] COLOR_CLUMP_RST =
      17'((64'({47'd0, COLOR_STEP_RST}) * 64'd24273 + 64'd32768) >> 16);

   localparam logic [17:0] FADE_K     = 18'd196608;
   localparam logic [16:0] OCT_FINE   = 17'd47186;
   localparam logic [16:0] OCT_CLUMP  = 17'd18350;

   localparam logic [15:0] LUM_R      = 16'd17841;
   localparam logic [15:0] LUM_G      = 16'd44176;
   localparam logic [15:0] LUM_B      = 16'd3519;
   localparam logic [17:0] TONE_KNEE  = 18'd1966;
   localparam logic [17:0] TONE_SPAN  = 18'd12452;
   localparam logic [28:0] TONE_RECIP = 29'd353200008;
   localparam logic [11:0] TONE_DIV   = 12'd3113;
   localparam logic [11:0] AMP_BASE   = 12'd1180;
   localparam logic [10:0] AMP_SPAN   = 11'd1442;
   localparam logic [8:0]  COLOR_AMP  = 9'd295;

   function automatic logic [15:0] sat16(input logic signed [19:0] v);
      logic [15:0] r;
      if (v < 0) begin
         r = 16'd0;
      end else if (v > 20'sd65535) begin
         r = 16'hffff;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

endpackage

>>> rtl/fgno_value_noise.sv
`timescale 1ns / 1ps
// one pipelined value noise field: lattice hash, smoothstep weights, blends
// depends on fgno_pkg
module fgno_value_noise
   import fgno_pkg::*;
#(
   parameter int COORD_W     = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic [COORD_W-1:0]            x,
   input  logic [COORD_W-1:0]            y,
   input  fgno_field_type                cfg,
   output logic signed [SAMPLE_BITS:0]   noise
);

   localparam int VW = SAMPLE_BITS + 1;
   localparam int DW = SAMPLE_BITS + 2;
   localparam int PW = DW + 18;
   localparam int UW = COORD_W + 17;
   localparam logic [DW-1:0] VAL_OFS = DW'((1 << SAMPLE_BITS) - 1);

   // c1
   logic [UW-1:0]  ux_ff, uy_ff;
   // c2
   logic [31:0]    hx_ff, hy_ff;
   logic [15:0]    fx_ff, fy_ff, fx2_ff, fy2_ff;
   // c3
   logic [31:0]    pre_ff [4];
   logic [16:0]    sx_ff [4];
   logic [16:0]    sy_ff [6];
   // c4, c5, c6
   logic [31:0]    m1_ff [4];
   logic [31:0]    m2_ff [4];
   logic signed [VW-1:0] val_ff [4];
   // c7 .. c10
   logic signed [PW-1:0] p0_ff, p1_ff, py_ff;
   logic signed [VW-1:0] v0_ff, v2_ff, a_ff, b_ff, a9_ff, n_ff;

   logic [31:0]    hx1, hy1;
   logic [31:0]    v [4];
   logic [31:0]    h [4];
   logic [SAMPLE_BITS-1:0] nb [4];
   logic [DW-1:0]  twon [4];
   logic [DW-1:0]  valw [4];
   logic [31:0]    m1x [4];
   logic [33:0]    sxp, syp;
   logic [31:0]    fxp, fyp;
   logic signed [DW-1:0] d0, d1, dy;
   logic signed [DW-1:0] a_full, b_full, n_full;

   always_comb begin
      hx1 = hx_ff + HASH_X;
      hy1 = hy_ff + HASH_Y;
      v[0] = hx_ff ^ hy_ff ^ cfg.seed;
      v[1] = hx1 ^ hy_ff ^ cfg.seed;
      v[2] = hx_ff ^ hy1 ^ cfg.seed;
      v[3] = hx1 ^ hy1 ^ cfg.seed;
      for (int i = 0; i < 4; i++) begin
         m1x[i]  = m1_ff[i] ^ (m1_ff[i] >> 15);
         h[i]    = m2_ff[i] ^ (m2_ff[i] >> 16);
         nb[i]   = h[i][23:24-SAMPLE_BITS];
         twon[i] = {1'b0, nb[i], 1'b0};
         valw[i] = twon[i] - VAL_OFS;
      end
      fxp = {16'd0, ux_ff[15:0]} * {16'd0, ux_ff[15:0]};
      fyp = {16'd0, uy_ff[15:0]} * {16'd0, uy_ff[15:0]};
      sxp = {18'd0, fx2_ff} * {16'd0, FADE_K - {1'b0, fx_ff, 1'b0}};
      syp = {18'd0, fy2_ff} * {16'd0, FADE_K - {1'b0, fy_ff, 1'b0}};
      d0 = DW'(val_ff[1]) - DW'(val_ff[0]);
      d1 = DW'(val_ff[3]) - DW'(val_ff[2]);
      a_full = DW'(v0_ff) + DW'(p0_ff >>> 16);
      b_full = DW'(v2_ff) + DW'(p1_ff >>> 16);
      dy = DW'(b_ff) - DW'(a_ff);
      n_full = DW'(a9_ff) + DW'(py_ff >>> 16);
   end

   always_ff @(posedge clock) begin
      ux_ff  <= UW'({17'd0, x} * {{COORD_W{1'b0}}, cfg.step});
      uy_ff  <= UW'({17'd0, y} * {{COORD_W{1'b0}}, cfg.step});
      hx_ff  <= 32'(ux_ff[UW-1:16]) * HASH_X;
      hy_ff  <= 32'(uy_ff[UW-1:16]) * HASH_Y;
      fx_ff  <= ux_ff[15:0];
      fy_ff  <= uy_ff[15:0];
      fx2_ff <= fxp[31:16];
      fy2_ff <= fyp[31:16];
      sx_ff[0] <= sxp[32:16];
      sy_ff[0] <= syp[32:16];
      for (int i = 1; i < 4; i++) begin
         sx_ff[i] <= sx_ff[i-1];
      end
      for (int i = 1; i < 6; i++) begin
         sy_ff[i] <= sy_ff[i-1];
      end
      for (int i = 0; i < 4; i++) begin
         pre_ff[i] <= v[i] ^ (v[i] >> 16);
         m1_ff[i]  <= pre_ff[i] * MIX_M1;
         m2_ff[i]  <= m1x[i] * MIX_M2;
         val_ff[i] <= valw[i][VW-1:0];
      end
      p0_ff <= d0 * $signed({1'b0, sx_ff[3]});
      p1_ff <= d1 * $signed({1'b0, sx_ff[3]});
      v0_ff <= val_ff[0];
      v2_ff <= val_ff[2];
      a_ff  <= a_full[VW-1:0];
      b_ff  <= b_full[VW-1:0];
      py_ff <= dy * $signed({1'b0, sy_ff[5]});
      a9_ff <= a_ff;
      n_ff  <= n_full[VW-1:0];
   end

   assign noise = n_ff;

endmodule

>>> rtl/fgno_two_octave.sv
`timescale 1ns / 1ps
// fine and clump value noise fields and their weighted sum
// depends on fgno_pkg and fgno_value_noise
module fgno_two_octave
   import fgno_pkg::*;
#(
   parameter int COORD_W     = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                          clock,
   input  logic [COORD_W-1:0]            x,
   input  logic [COORD_W-1:0]            y,
   input  fgno_field_type                fine_cfg,
   input  fgno_field_type                clump_cfg,
   output logic signed [SAMPLE_BITS:0]   noise
);

   localparam int VW = SAMPLE_BITS + 1;

   logic signed [VW-1:0]    fine, clump;
   logic signed [VW+17:0]   pf_ff, pc_ff;
   logic signed [VW+18:0]   sum;
   logic signed [VW+18:0]   sum_sh;
   logic signed [VW-1:0]    noise_ff;

   fgno_value_noise #(.COORD_W(COORD_W), .SAMPLE_BITS(SAMPLE_BITS)) u_fine (
      .clock (clock),
      .x     (x),
      .y     (y),
      .cfg   (fine_cfg),
      .noise (fine)
   );

   fgno_value_noise #(.COORD_W(COORD_W), .SAMPLE_BITS(SAMPLE_BITS)) u_clump (
      .clock (clock),
      .x     (x),
      .y     (y),
      .cfg   (clump_cfg),
      .noise (clump)
   );

   assign sum    = (VW+19)'(pf_ff) + (VW+19)'(pc_ff);
   assign sum_sh = sum >>> 16;

   always_ff @(posedge clock) begin
      pf_ff    <= fine * $signed({1'b0, OCT_FINE});
      pc_ff    <= clump * $signed({1'b0, OCT_CLUMP});
      noise_ff <= sum_sh[VW-1:0];
   end

   assign noise = noise_ff;

endmodule

>>> rtl/fgno_tone.sv
`timescale 1ns / 1ps
// luminance, shadow density and grain amplitude times gain, nine stages
// depends on fgno_pkg
module fgno_tone
   import fgno_pkg::*;
(
   input  logic          clock,
   input  fgno_req_type  pix,
   input  logic [15:0]   gain,
   output logic [27:0]   gain_amp
);

   logic [31:0] pr_ff, pg_ff, pb_ff;
   logic        sat2_ff, sat3_ff, sat4_ff;
   logic [13:0] t2_ff, t3_ff, t4_ff;
   logic [42:0] qp_ff;
   logic [15:0] q0_ff;
   logic [27:0] qq_ff;
   logic [16:0] tv_ff, tv6_ff, f2_ff, s_ff;
   logic [11:0] amp_ff;
   logic [27:0] ga_ff;

   logic [32:0] lsum;
   logic signed [17:0] d;
   logic [27:0] num, rem;
   logic [15:0] q;
   logic [33:0] tsq;
   logic [34:0] sp;
   logic [16:0] dens;
   logic [27:0] ap;

   always_comb begin
      lsum = {1'b0, pr_ff} + {1'b0, pg_ff} + {1'b0, pb_ff};
      d    = $signed({2'b00, lsum[31:16]}) - $signed(TONE_KNEE);
      if (d < 0) begin
         d = 18'sd0;
      end
      num  = {t4_ff, 14'd0};
      rem  = num - qq_ff;
      q    = (rem >= {16'd0, TONE_DIV}) ? q0_ff + 16'd1 : q0_ff;
      tsq  = {17'd0, tv_ff} * {17'd0, tv_ff};
      sp   = {18'd0, f2_ff} * {17'd0, FADE_K - {tv6_ff, 1'b0}};
      dens = STEP_MAX - s_ff;
      ap   = {17'd0, AMP_SPAN} * {11'd0, dens};
   end

   always_ff @(posedge clock) begin
      pr_ff   <= {16'd0, pix.red_in} * {16'd0, LUM_R};
      pg_ff   <= {16'd0, pix.green_in} * {16'd0, LUM_G};
      pb_ff   <= {16'd0, pix.blue_in} * {16'd0, LUM_B};
      sat2_ff <= (d >= $signed(TONE_SPAN));
      t2_ff   <= d[13:0];
      qp_ff   <= {29'd0, t2_ff} * {14'd0, TONE_RECIP};
      t3_ff   <= t2_ff;
      sat3_ff <= sat2_ff;
      q0_ff   <= qp_ff[41:26];
      qq_ff   <= {12'd0, qp_ff[41:26]} * {16'd0, TONE_DIV};
      t4_ff   <= t3_ff;
      sat4_ff <= sat3_ff;
      tv_ff   <= sat4_ff ? STEP_MAX : {1'b0, q};
      f2_ff   <= tsq[32:16];
      tv6_ff  <= tv_ff;
      s_ff    <= sp[32:16];
      amp_ff  <= AMP_BASE + {1'b0, ap[26:16]};
      ga_ff   <= {12'd0, gain} * {16'd0, amp_ff};
   end

   assign gain_amp = ga_ff;

endmodule

>>> rtl/film_grain_noise_overlay_core.sv
`timescale 1ns / 1ps
// film grain overlay top: registers, noise fields, tone path, output stage
// depends on fgno_pkg, fgno_two_octave and fgno_tone
// an accepted request gets its rsp_valid strobe after the request, noise, gain and output registers
// throughput: one request per clock outside reset, set by the fully pipelined hash and blend stages
// the receiver cannot stall; every result shows for exactly one cycle
// reset (synchronous) clears the pipeline valids and loads register defaults
// busy is high only while reset is asserted
module film_grain_noise_overlay_core
   import fgno_pkg::*;
#(
   parameter int COORD_BITS  = 16,
   parameter int SAMPLE_BITS = 16
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   input  fgno_req_type  req_data,
   output logic          rsp_valid,
   output fgno_rsp_type  rsp_data,
   input  logic          csr_we,
   input  logic [1:0]    csr_index,
   input  logic [31:0]   csr_data
);

   localparam int CW  = (COORD_BITS < 16) ? COORD_BITS : 16;
   localparam int VW  = SAMPLE_BITS + 1;
   localparam int LAT = 16;
   localparam int SH  = SAMPLE_BITS + 18;

   logic [31:0] seed_ff, seed_in;
   logic [16:0] step_ff, step_in;
   logic [15:0] gain_ff, gain_in;
   logic [16:0] clump_step_ff, color_step_ff, color_clump_ff;
   logic [24:0] g295_ff;
   logic [31:0] clump_p, color_p, color_clump_p;

   logic [LAT-1:0] valid_ff, valid_in;
   fgno_req_type   req0_ff;
   logic [CW-1:0]  x1_ff, y1_ff;
   fgno_req_type   pix_d_ff [14];
   logic [27:0]    ga_d_ff [4];
   logic [27:0]    gain_amp;
   logic signed [VW-1:0] gm, gc;
   logic signed [VW+28:0] pm_ff;
   logic signed [VW+25:0] pc_ff;
   logic signed [VW+28:0] pm_sh;
   logic signed [VW+25:0] pc_sh;
   logic signed [19:0] mono, col, r_sum, g_sum, b_sum;
   fgno_rsp_type   rsp_ff;
   fgno_field_type mono_fine, mono_clump, col_fine, col_clump;
   logic           accept;

   assign busy   = reset;
   assign accept = start & ~busy;

   always_comb begin
      seed_in = seed_ff;
      step_in = step_ff;
      gain_in = gain_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SEED: begin
               seed_in = (csr_data == 32'd0) ? 32'd1 : csr_data;
            end
            CSR_STEP: begin
               if (csr_data[16:0] == 17'd0) begin
                  step_in = 17'd1;
               end else if (csr_data[16:0] > STEP_MAX) begin
                  step_in = STEP_MAX;
               end else begin
                  step_in = csr_data[16:0];
               end
            end
            CSR_GAIN: begin
               gain_in = csr_data[15:0];
            end
            default: begin
            end
         endcase
      end
      clump_p       = {15'd0, step_ff} * CLUMP_K + ROUND_HALF;
      color_p       = {15'd0, step_ff} * COLOR_K + ROUND_HALF;
      color_clump_p = {15'd0, color_step_ff} * CLUMP_K + ROUND_HALF;
      valid_in      = {valid_ff[LAT-2:0], accept};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff        <= 32'd1;
         step_ff        <= STEP_MAX;
         gain_ff        <= 16'd0;
         clump_step_ff  <= CLUMP_STEP_RST;
         color_step_ff  <= COLOR_STEP_RST;
         color_clump_ff <= COLOR_CLUMP_RST;
         g295_ff        <= 25'd0;
         valid_ff       <= '0;
      end else begin
         seed_ff        <= seed_in;
         step_ff        <= step_in;
         gain_ff        <= gain_in;
         clump_step_ff  <= {1'b0, clump_p[31:16]};
         color_step_ff  <= {1'b0, color_p[31:16]};
         color_clump_ff <= {1'b0, color_clump_p[31:16]};
         g295_ff        <= {9'd0, gain_ff} * {16'd0, COLOR_AMP};
         valid_ff       <= valid_in;
      end
   end

   assign mono_fine  = '{step: step_ff,        seed: seed_ff};
   assign mono_clump = '{step: clump_step_ff,  seed: seed_ff ^ SEED_CLUMP};
   assign col_fine   = '{step: color_step_ff,  seed: seed_ff ^ SEED_COLOR};
   assign col_clump  = '{step: color_clump_ff, seed: seed_ff ^ SEED_COLOR ^ SEED_CLUMP};

   fgno_two_octave #(.COORD_W(CW), .SAMPLE_BITS(SAMPLE_BITS)) u_mono (
      .clock     (clock),
      .x         (x1_ff),
      .y         (y1_ff),
      .fine_cfg  (mono_fine),
      .clump_cfg (mono_clump),
      .noise     (gm)
   );

   fgno_two_octave #(.COORD_W(CW), .SAMPLE_BITS(SAMPLE_BITS)) u_color (
      .clock     (clock),
      .x         (x1_ff),
      .y         (y1_ff),
      .fine_cfg  (col_fine),
      .clump_cfg (col_clump),
      .noise     (gc)
   );

   fgno_tone u_tone (
      .clock    (clock),
      .pix      (req0_ff),
      .gain     (gain_ff),
      .gain_amp (gain_amp)
   );

   always_comb begin
      pm_sh = pm_ff >>> SH;
      pc_sh = pc_ff >>> SH;
      mono  = pm_sh[19:0];
      col   = pc_sh[19:0];
      r_sum = $signed({4'd0, pix_d_ff[13].red_in}) + mono + col;
      g_sum = $signed({4'd0, pix_d_ff[13].green_in}) + mono;
      b_sum = $signed({4'd0, pix_d_ff[13].blue_in}) + mono - col;
   end

   always_ff @(posedge clock) begin
      req0_ff <= req_data;
      x1_ff   <= req0_ff.pixel_x[CW-1:0];
      y1_ff   <= req0_ff.pixel_y[CW-1:0];
      pix_d_ff[0] <= req0_ff;
      for (int i = 1; i < 14; i++) begin
         pix_d_ff[i] <= pix_d_ff[i-1];
      end
      ga_d_ff[0] <= gain_amp;
      for (int i = 1; i < 4; i++) begin
         ga_d_ff[i] <= ga_d_ff[i-1];
      end
      pm_ff <= gm * $signed({1'b0, ga_d_ff[3]});
      pc_ff <= gc * $signed({1'b0, g295_ff});
      rsp_ff.red_out   <= sat16(r_sum);
      rsp_ff.green_out <= sat16(g_sum);
      rsp_ff.blue_out  <= sat16(b_sum);
   end

   assign rsp_valid = valid_ff[LAT-1];
   assign rsp_data  = rsp_ff;

   a_rsp_from_request: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, LAT))
      else $error("result without a matching request");

   a_seed_nonzero: assert property (@(posedge clock) disable iff (reset)
      seed_ff != 32'd0)
      else $error("seed register holds zero");

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff != 17'd0 && step_ff <= STEP_MAX)
      else $error("cell step out of range");

endmodule

>>> tb/film_grain_noise_overlay_core_tb.sv
`timescale 1ns / 1ps
// testbench of film_grain_noise_overlay_core: directed and random pixels through a
// bit-exact grain predictor, results checked in order against a queue of expected pixels
// depends on fgno_pkg and the rtl of the core
module film_grain_noise_overlay_core_tb;
   import fgno_pkg::*;

   localparam int COORD_W  = 16;
   localparam int SAMPLE_W = 16;
   localparam int LATENCY  = 16;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   fgno_req_type req_data = '0;
   logic         rsp_valid;
   fgno_rsp_type rsp_data;
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = 2'd0;
   logic [31:0]  csr_data = '0;

   logic [31:0] seed_reg;
   logic [16:0] step_reg;
   logic [15:0] gain_reg;

   fgno_rsp_type pixel_q[$];
   int errors = 0;
   bit idle_on = 1'b1;

   film_grain_noise_overlay_core #(.COORD_BITS(COORD_W), .SAMPLE_BITS(SAMPLE_W)) u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_data(rsp_data), .csr_we(csr_we),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   function automatic longint floor_shr(longint v, int sh);
      return v >>> sh;
   endfunction

   function automatic logic [31:0] hash_mix(logic [31:0] v);
      v = v ^ (v >> 16);
      v = v * MIX_M1;
      v = v ^ (v >> 15);
      v = v * MIX_M2;
      v = v ^ (v >> 16);
      return v;
   endfunction

   function automatic longint corner_value(logic [31:0] ix, logic [31:0] iy, logic [31:0] sd);
      logic [31:0] h;
      longint n;
      h = hash_mix((ix * HASH_X) ^ (iy * HASH_Y) ^ sd);
      n = longint'((h & 32'h00ffffff) >> (24 - SAMPLE_W));
      return 2 * n - ((longint'(1) << SAMPLE_W) - 1);
   endfunction

   function automatic longint smooth_weight(longint f);
      longint f2;
      f2 = (f * f) >> 16;
      return (f2 * (196608 - 2 * f)) >> 16;
   endfunction

   function automatic longint lerp_q16(longint a, longint b, longint s);
      return a + floor_shr((b - a) * s, 16);
   endfunction

   function automatic logic [31:0] scaled_step(logic [31:0] st, longint k);
      return 32'((longint'(st) * k + 32768) >> 16);
   endfunction

   function automatic longint lattice_noise(longint x, longint y, logic [31:0] st,
                                            logic [31:0] sd);
      longint ux, uy, sx, sy, a, b;
      logic [31:0] x0, y0;
      ux = x * longint'(st);
      uy = y * longint'(st);
      x0 = 32'(ux >> 16);
      y0 = 32'(uy >> 16);
      sx = smooth_weight(ux & 'hffff);
      sy = smooth_weight(uy & 'hffff);
      a = lerp_q16(corner_value(x0, y0, sd), corner_value(x0 + 1, y0, sd), sx);
      b = lerp_q16(corner_value(x0, y0 + 1, sd), corner_value(x0 + 1, y0 + 1, sd), sx);
      return lerp_q16(a, b, sy);
   endfunction

   function automatic longint octave_noise(longint x, longint y, logic [31:0] st,
                                           logic [31:0] sd);
      longint fine, clump;
      fine = lattice_noise(x, y, st, sd);
      clump = lattice_noise(x, y, scaled_step(st, 24273), sd ^ SEED_CLUMP);
      return floor_shr(fine * 47186 + clump * 18350, 16);
   endfunction

   function automatic logic [15:0] clip16(longint v);
      if (v < 0) begin
         return 16'd0;
      end else if (v > 65535) begin
         return 16'hffff;
      end
      return 16'(v);
   endfunction

   function automatic fgno_rsp_type grain_pixel(fgno_req_type p);
      longint x, y, r, g, b, lum, t, dens, amp, gm, gc, mono, col;
      logic [31:0] sd, st;
      fgno_rsp_type o;
      x = longint'(p.pixel_x) & ((longint'(1) << COORD_W) - 1);
      y = longint'(p.pixel_y) & ((longint'(1) << COORD_W) - 1);
      r = p.red_in;
      g = p.green_in;
      b = p.blue_in;
      sd = (seed_reg == 0) ? 32'd1 : seed_reg;
      st = step_reg;
      if (st == 0) begin
         st = 1;
      end
      if (st > 65536) begin
         st = 65536;
      end
      lum = (r * 17841 + g * 44176 + b * 3519) >> 16;
      t = lum - 1966;
      if (t < 0) begin
         t = 0;
      end
      t = (t * 65536) / 12452;
      if (t > 65536) begin
         t = 65536;
      end
      dens = 65536 - smooth_weight(t);
      amp = 1180 + ((1442 * dens) >> 16);
      gm = octave_noise(x, y, st, sd);
      gc = octave_noise(x, y, scaled_step(st, 48545), sd ^ SEED_COLOR);
      mono = floor_shr(gm * longint'(gain_reg) * amp, SAMPLE_W + 18);
      col = floor_shr(gc * longint'(gain_reg) * 295, SAMPLE_W + 18);
      o.red_out = clip16(r + mono + col);
      o.green_out = clip16(g + mono);
      o.blue_out = clip16(b + mono - col);
      return o;
   endfunction

   task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   always @(posedge clock) begin
      fgno_rsp_type want;
      if (!reset && rsp_valid) begin
         if (pixel_q.size() == 0) begin
            $display("unexpected result at %0t", $realtime);
            errors++;
         end else begin
            want = pixel_q.pop_front();
            if (rsp_data.red_out !== want.red_out) begin
               report_mismatch("red", rsp_data.red_out, want.red_out);
            end
            if (rsp_data.green_out !== want.green_out) begin
               report_mismatch("green", rsp_data.green_out, want.green_out);
            end
            if (rsp_data.blue_out !== want.blue_out) begin
               report_mismatch("blue", rsp_data.blue_out, want.blue_out);
            end
         end
      end
   end

   task automatic send_pixel(fgno_req_type p);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= p;
      @(posedge clock);
      while (busy) begin
         @(posedge clock);
      end
      pixel_q.push_back(grain_pixel(p));
   endtask

   task automatic drain_pipe();
      start <= 1'b0;
      @(posedge clock);
      while (pixel_q.size() != 0) begin
         @(posedge clock);
      end
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_reg(fgno_csr_type idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         CSR_SEED: seed_reg = val;
         CSR_STEP: step_reg = val[16:0];
         CSR_GAIN: gain_reg = val[15:0];
         default: ;
      endcase
   endtask

   function automatic fgno_req_type random_pixel();
      fgno_req_type p;
      p = fgno_req_type'({$urandom, $urandom, 16'($urandom)});
      case ($urandom_range(0, 3))
         0: p.red_in = 16'hffff - 16'($urandom_range(0, 300));
         1: p.green_in = 16'($urandom_range(0, 3000));
         default: ;
      endcase
      return p;
   endfunction

   task automatic set_field(logic [31:0] sd, logic [16:0] st, logic [15:0] gn);
      write_reg(CSR_SEED, sd);
      write_reg(CSR_STEP, {15'd0, st});
      write_reg(CSR_GAIN, {16'd0, gn});
   endtask

   task automatic test_pass_through();
      fgno_req_type p;
      p = '0;
      send_pixel(p);
      p = '1;
      send_pixel(p);
      repeat (4) send_pixel(random_pixel());
      drain_pipe();
   endtask

   task automatic test_directed();
      fgno_req_type p;
      set_field(32'd0, 17'd0, 16'hffff);
      p = '0;
      send_pixel(p);
      p = '1;
      send_pixel(p);
      drain_pipe();
      set_field(32'hffffffff, 17'h1ffff, 16'hffff);
      p = '{16'hffff, 16'd0, 16'd0, 16'd0, 16'hffff};
      send_pixel(p);
      p = '{16'd0, 16'hffff, 16'hffff, 16'hffff, 16'd0};
      send_pixel(p);
      p = '{16'h1234, 16'h8765, 16'd1966, 16'd1966, 16'd1966};
      send_pixel(p);
      p = '{16'd7, 16'd9, 16'd14418, 16'd14418, 16'd14418};
      send_pixel(p);
      drain_pipe();
      set_field(32'h9e3779b9, 17'd1, 16'd40000);
      p = '{16'hffff, 16'hffff, 16'd100, 16'd100, 16'd100};
      send_pixel(p);
      repeat (5) send_pixel(random_pixel());
      drain_pipe();
      set_field(32'h5a5a1234, 17'd65537, 16'd1);
      repeat (4) send_pixel(random_pixel());
      drain_pipe();
   endtask

   task automatic test_random(int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) begin
            drain_pipe();
            case ($urandom_range(0, 3))
               0: set_field($urandom, 17'($urandom_range(1, 65536)), 16'($urandom));
               1: set_field($urandom, 17'($urandom_range(1, 300)), 16'hffff);
               2: set_field($urandom, 17'($urandom_range(60000, 131071)), 16'($urandom));
               default: set_field($urandom, 17'($urandom), 16'($urandom_range(0, 20)));
            endcase
         end
         idle_on = (i < count - 120) && ((i / 37) % 3 != 0);
         send_pixel(random_pixel());
      end
      drain_pipe();
   endtask

   initial begin
      seed_reg = 32'd1;
      step_reg = 17'd65536;
      gain_reg = 16'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_pass_through();
      test_directed();
      test_random(700);
      if (errors == 0) begin
         $display("film_grain_noise_overlay_core_tb passed");
      end else begin
         $display("film_grain_noise_overlay_core_tb failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("film_grain_noise_overlay_core_tb failed");
      $finish;
   end

endmodule

>>> film_grain_noise_overlay_core.f
rtl/fgno_pkg.sv
rtl/fgno_value_noise.sv
rtl/fgno_two_octave.sv
rtl/fgno_tone.sv
rtl/film_grain_noise_overlay_core.sv
tb/film_grain_noise_overlay_core_tb.sv
